// ----- src/mcc_pkg.sv -----
// Shared constants and command types of the multichannel coulomb counter.
`timescale 1ns / 1ps
`default_nettype none
package mcc_pkg;
  localparam int CHANNELS     = 16;
  localparam int CH_BITS      = 4;
  localparam int CUR_BITS     = 16;
  localparam int MAG_BITS     = CUR_BITS + 1;
  localparam int ELAPSED_BITS = 32;
  localparam int PROD_BITS    = MAG_BITS + ELAPSED_BITS;
  localparam int ACC_BITS     = 48;
  localparam int TOT_BITS     = 52;
  localparam int CIU_BITS     = 5;
  localparam int ADDR_BITS    = 3;

  localparam logic [CIU_BITS-1:0] CIU_RESET = CIU_BITS'(16);
  localparam logic [CIU_BITS:0]   CH_LIMIT  = (CIU_BITS+1)'(CHANNELS);

  typedef struct packed {
    logic load;
    logic commit;
    logic clear;
  } mcc_cmd_t;
endpackage
`default_nettype wire

// ----- src/mcc_ctrl.sv -----
// Sequencer of the coulomb counter: accept, commit and result strobe.
`timescale 1ns / 1ps
`default_nettype none
module mcc_ctrl import mcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic cfg_wr,
  output mcc_cmd_t  cmd,
  output logic      busy,
  output logic      done
);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy       = (state == ST_EXEC);
  assign cmd.load   = start && (state == ST_IDLE);
  assign cmd.commit = (state == ST_EXEC);
  assign cmd.clear  = cfg_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit;
    end
  end

`ifndef SYNTHESIS
  a_load_then_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> busy) else $error("accepted beat did not enter execution");
  a_commit_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> done && !busy) else $error("commit not followed by result strobe");
  a_done_from_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.commit)) else $error("result strobe without commit");
  a_no_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load) else $error("beat accepted while busy");
`endif
endmodule
`default_nettype wire

// ----- src/mcc_dp.sv -----
// Datapath of the coulomb counter: channel stores, multiplier, totals, result registers.
`timescale 1ns / 1ps
`default_nettype none
module mcc_dp import mcc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mcc_cmd_t                  cmd,
  input  wire logic [CIU_BITS-1:0]       channels_in_use,
  input  wire logic [CH_BITS-1:0]        channel,
  input  wire logic signed [CUR_BITS-1:0] current_ma,
  input  wire logic                      sample_valid,
  input  wire logic [ELAPSED_BITS-1:0]   elapsed_ms,
  output logic [ACC_BITS-1:0]            channel_discharge,
  output logic [ACC_BITS-1:0]            channel_charge,
  output logic [TOT_BITS-1:0]            sum_discharge,
  output logic [TOT_BITS-1:0]            sum_charge,
  output logic                           rejected
);
  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;
  localparam logic [TOT_BITS-1:0] TOT_MAX = '1;

  logic [ACC_BITS-1:0] mem_d [CHANNELS];
  logic [ACC_BITS-1:0] mem_c [CHANNELS];
  logic [CHANNELS-1:0] entry_valid;

  logic [CH_BITS-1:0]   ch;
  logic                 neg;
  logic                 do_acc;
  logic                 rej;
  logic [PROD_BITS-1:0] prod;
  logic [ACC_BITS-1:0]  rd_d;
  logic [ACC_BITS-1:0]  rd_c;
  logic                 rd_v;
  logic [TOT_BITS-1:0]  tot_d;
  logic [TOT_BITS-1:0]  tot_c;

  logic [CIU_BITS:0]     active;
  logic                  in_rej;
  logic [MAG_BITS-1:0]   cur_ext;
  logic [MAG_BITS-1:0]   mag;
  logic [ACC_BITS-1:0]   old_d;
  logic [ACC_BITS-1:0]   old_c;
  logic [ACC_BITS-1:0]   old_sel;
  logic [PROD_BITS:0]    acc_sum;
  logic                  acc_sat;
  logic [ACC_BITS-1:0]   new_sel;
  logic [PROD_BITS-1:0]  delta;
  logic [TOT_BITS-1:0]   tot_sel;
  logic [TOT_BITS:0]     tot_sum;
  logic [TOT_BITS-1:0]   tot_new;
  logic [ACC_BITS-1:0]   new_d;
  logic [ACC_BITS-1:0]   new_c;
  logic [TOT_BITS-1:0]   tot_d_next;
  logic [TOT_BITS-1:0]   tot_c_next;

  always_comb begin
    active  = ({1'b0, channels_in_use} < CH_LIMIT) ? {1'b0, channels_in_use} : CH_LIMIT;
    in_rej  = ({{(CIU_BITS+1-CH_BITS){1'b0}}, channel} >= active);
    cur_ext = {current_ma[CUR_BITS-1], current_ma};
    mag     = current_ma[CUR_BITS-1] ? (MAG_BITS'(0) - cur_ext) : cur_ext;
  end

  always_comb begin
    old_d   = rd_v ? rd_d : '0;
    old_c   = rd_v ? rd_c : '0;
    old_sel = neg ? old_c : old_d;
    acc_sum = {{(PROD_BITS+1-ACC_BITS){1'b0}}, old_sel} + {1'b0, prod};
    acc_sat = (acc_sum > {{(PROD_BITS+1-ACC_BITS){1'b0}}, ACC_MAX});
    new_sel = acc_sat ? ACC_MAX : acc_sum[ACC_BITS-1:0];
    delta   = acc_sat ? {{(PROD_BITS-ACC_BITS){1'b0}}, ACC_MAX - old_sel} : prod;
    tot_sel = neg ? tot_c : tot_d;
    tot_sum = {1'b0, tot_sel} + {{(TOT_BITS+1-PROD_BITS){1'b0}}, delta};
    tot_new = tot_sum[TOT_BITS] ? TOT_MAX : tot_sum[TOT_BITS-1:0];
    new_d = old_d;
    new_c = old_c;
    tot_d_next = tot_d;
    tot_c_next = tot_c;
    if (do_acc) begin
      if (neg) begin
        new_c      = new_sel;
        tot_c_next = tot_new;
      end else begin
        new_d      = new_sel;
        tot_d_next = tot_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch     <= channel;
      neg    <= current_ma[CUR_BITS-1];
      rej    <= in_rej;
      do_acc <= !in_rej && sample_valid && (elapsed_ms != '0) && (current_ma != '0);
      prod   <= PROD_BITS'(mag) * PROD_BITS'(elapsed_ms);
      rd_d   <= mem_d[channel];
      rd_c   <= mem_c[channel];
      rd_v   <= entry_valid[channel];
    end
    if (cmd.commit && do_acc) begin
      mem_d[ch] <= new_d;
      mem_c[ch] <= new_c;
    end
    if (cmd.commit) begin
      channel_discharge <= rej ? '0 : new_d;
      channel_charge    <= rej ? '0 : new_c;
      sum_discharge     <= tot_d_next;
      sum_charge        <= tot_c_next;
      rejected          <= rej;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      entry_valid <= '0;
      tot_d       <= '0;
      tot_c       <= '0;
    end else if (cmd.commit && do_acc) begin
      entry_valid[ch] <= 1'b1;
      tot_d           <= tot_d_next;
      tot_c           <= tot_c_next;
    end
  end

`ifndef SYNTHESIS
  a_rej_no_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && rej) |=> $stable(tot_d) && $stable(tot_c))
    else $error("rejected beat changed the totals");
  a_totals_grow: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !cmd.clear) |=> (tot_d >= $past(tot_d)) && (tot_c >= $past(tot_c)))
    else $error("total decreased without a clear");
  a_one_store_per_beat: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !cmd.clear) |=> $stable(tot_d) || $stable(tot_c))
    else $error("both totals changed on one beat");
`endif
endmodule
`default_nettype wire

// ----- src/multichannel_coulomb_counter_unit.sv -----
// Top level of the multichannel coulomb counter: register port and block integration.
`timescale 1ns / 1ps
`default_nettype none
// In each beat, the accept edge reads the channel's stores and registers the
// current-times-time product, the next edge writes the updated stores and totals back and
// loads the result, which shows for one cycle with done high. busy is high in the cycle in
// between, so a new beat can start in the same cycle as done, but not while busy; the
// read-then-write of the channel memory is why. Results cannot be held off.
// Writing channels_in_use (address 0) clears all stores and totals in that same cycle,
// with no clearing pass; it must be written only while the block is idle.
module multichannel_coulomb_counter_unit import mcc_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ADDR_BITS-1:0]       paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire logic                       start,
  output logic                            busy,
  output logic                            done,
  input  wire logic [CH_BITS-1:0]         channel,
  input  wire logic signed [CUR_BITS-1:0] current_ma,
  input  wire logic                       sample_valid,
  input  wire logic [ELAPSED_BITS-1:0]    elapsed_ms,
  output logic [ACC_BITS-1:0]             channel_discharge,
  output logic [ACC_BITS-1:0]             channel_charge,
  output logic [TOT_BITS-1:0]             sum_discharge,
  output logic [TOT_BITS-1:0]             sum_charge,
  output logic                            rejected
);
  logic [CIU_BITS-1:0] channels_in_use;
  logic                cfg_wr;
  mcc_cmd_t            cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_BITS-1] == 1'b0);
  assign prdata = (paddr[ADDR_BITS-1] == 1'b0) ? {{(32-CIU_BITS){1'b0}}, channels_in_use}
                                               : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CIU_RESET;
    end else if (cfg_wr) begin
      channels_in_use <= pwdata[CIU_BITS-1:0];
    end
  end

  mcc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_wr (cfg_wr),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mcc_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .channels_in_use   (channels_in_use),
    .channel           (channel),
    .current_ma        (current_ma),
    .sample_valid      (sample_valid),
    .elapsed_ms        (elapsed_ms),
    .channel_discharge (channel_discharge),
    .channel_charge    (channel_charge),
    .sum_discharge     (sum_discharge),
    .sum_charge        (sum_charge),
    .rejected          (rejected)
  );
endmodule
`default_nettype wire
